@@ rtl/rgbhsv_pkg.sv @@
// Types and constants shared by the RGB to HSV converter.
package rgbhsv_pkg;

    localparam int COMP_W     = 8;
    localparam int QUOT_BITS  = 8;
    localparam int NUM_W      = 11;
    localparam int REM_SAT_W  = 16;
    localparam int REM_HUE_W  = 19;
    localparam int DIV_STAGE0 = 2;
    localparam int NUM_STAGES = DIV_STAGE0 + QUOT_BITS;

    typedef struct packed {
        logic [REM_SAT_W-1:0] rem_sat;
        logic [REM_HUE_W-1:0] rem_hue;
        logic [COMP_W-1:0]    div_sat;
        logic [NUM_W-1:0]     div_hue;
        logic [QUOT_BITS-1:0] q_sat;
        logic [QUOT_BITS-1:0] q_hue;
        logic [COMP_W-1:0]    bri;
        logic                 gray;
        logic                 black;
    } stage_t;

endpackage

@@ rtl/rgb_to_hsv_converter_unit.sv @@
// Pipelined RGB to HSV converter for 8-bit pixels.
// The block takes one pixel per clock while s_tready is high and returns its hue,
// saturation and value. Stage one finds the largest and smallest component and the
// hue sector numerator, stage two scales both numerators by 255, and eight more
// stages each resolve one quotient bit of the two divisions by restoring
// subtraction; the last of these drives the output. Every stage holds its item
// while the next one is full, so a stall at the output fills empty stages before
// the input stops.
module rgb_to_hsv_converter_unit
    import rgbhsv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // hue [7:0], saturation [15:8], brightness [23:16]
);

    localparam int LAST = NUM_STAGES - 1;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES:0]   ready;
    stage_t                stage_reg  [NUM_STAGES];
    stage_t                stage_next [NUM_STAGES];

    logic [COMP_W-1:0] red, green, blue;
    logic [COMP_W-1:0] hi, lo, delta;
    logic [NUM_W-1:0]  delta_w, num;

    assign red   = s_tdata[7:0];
    assign green = s_tdata[15:8];
    assign blue  = s_tdata[23:16];

    always_comb begin
        hi      = (red >= green) ? red : green;
        hi      = (hi >= blue) ? hi : blue;
        lo      = (red <= green) ? red : green;
        lo      = (lo <= blue) ? lo : blue;
        delta   = hi - lo;
        delta_w = {3'b000, delta};
        if (red >= green && red >= blue) begin
            num = {3'b000, green} - {3'b000, blue};
            if (green < blue) begin
                num = num + (delta_w << 2) + (delta_w << 1);
            end
        end else if (green >= blue) begin
            num = {3'b000, blue} - {3'b000, red} + (delta_w << 1);
        end else begin
            num = {3'b000, red} - {3'b000, green} + (delta_w << 2);
        end
    end

    always_comb begin
        logic [REM_SAT_W:0] trial_sat;
        logic [REM_HUE_W:0] trial_hue;
        for (int i = 0; i < NUM_STAGES; i++) begin
            stage_next[i] = '0;
        end
        trial_sat = '0;
        trial_hue = '0;

        stage_next[0].rem_sat = {{(REM_SAT_W-COMP_W){1'b0}}, delta};
        stage_next[0].rem_hue = {{(REM_HUE_W-NUM_W){1'b0}}, num};
        stage_next[0].div_sat = hi;
        stage_next[0].div_hue = (delta_w << 2) + (delta_w << 1);
        stage_next[0].bri     = hi;
        stage_next[0].gray    = (delta == '0);
        stage_next[0].black   = (hi == '0);

        stage_next[1]         = stage_reg[0];
        stage_next[1].rem_sat = (stage_reg[0].rem_sat << 8) - stage_reg[0].rem_sat;
        stage_next[1].rem_hue = (stage_reg[0].rem_hue << 8) - stage_reg[0].rem_hue;

        for (int i = DIV_STAGE0; i < NUM_STAGES; i++) begin
            stage_next[i] = stage_reg[i-1];
            trial_sat = {1'b0, stage_reg[i-1].rem_sat}
                      - ({{(REM_SAT_W+1-COMP_W){1'b0}}, stage_reg[i-1].div_sat}
                         << (NUM_STAGES - 1 - i));
            trial_hue = {1'b0, stage_reg[i-1].rem_hue}
                      - ({{(REM_HUE_W+1-NUM_W){1'b0}}, stage_reg[i-1].div_hue}
                         << (NUM_STAGES - 1 - i));
            if (!trial_sat[REM_SAT_W]) begin
                stage_next[i].rem_sat = trial_sat[REM_SAT_W-1:0];
            end
            if (!trial_hue[REM_HUE_W]) begin
                stage_next[i].rem_hue = trial_hue[REM_HUE_W-1:0];
            end
            stage_next[i].q_sat = {stage_reg[i-1].q_sat[QUOT_BITS-2:0],
                                   !trial_sat[REM_SAT_W]};
            stage_next[i].q_hue = {stage_reg[i-1].q_hue[QUOT_BITS-2:0],
                                   !trial_hue[REM_HUE_W]};
        end

        if (stage_reg[LAST-1].black) begin
            stage_next[LAST].q_sat = '0;
        end
        if (stage_reg[LAST-1].gray) begin
            stage_next[LAST].q_hue = '0;
        end
    end

    always_comb begin
        ready[NUM_STAGES] = m_tready;
        for (int i = NUM_STAGES - 1; i >= 0; i--) begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (ready[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (ready[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready[0] && s_tvalid) begin
            stage_reg[0] <= stage_next[0];
        end
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (ready[i] && valid_reg[i-1]) begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    assign s_tready = ready[0];
    assign m_tvalid = valid_reg[LAST];
    assign m_tdata  = {stage_reg[LAST].bri, stage_reg[LAST].q_sat, stage_reg[LAST].q_hue};

    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:0] != 8'hFF)
        else $error("hue reached 255");

    a_black_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[23:16] == 8'h00 |-> m_tdata[15:8] == 8'h00)
        else $error("black pixel with nonzero saturation");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> valid_reg == '1 && !m_tready)
        else $error("input stalled while the pipeline has room");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output item changed");

endmodule
